// ----- design/stack_and_lettered_queues_macros.svh -----
// ----------------------------------------------------------------------------
// stack_and_lettered_queues_macros.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_AND_LETTERED_QUEUES_MACROS_SVH
`define STACK_AND_LETTERED_QUEUES_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SALQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SALQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/salq_pkg.sv -----
// ----------------------------------------------------------------------------
// salq_pkg
// Types and codes for the stack and lettered queue block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package salq_pkg;

	localparam int DATA_W = 32;
	localparam int QIDX_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_ENQUEUE = 2'd2,
		OP_DEQUEUE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_STACK_EMPTY = 3'd1,
		ST_STACK_FULL  = 3'd2,
		ST_QUEUE_EMPTY = 3'd3,
		ST_QUEUE_FULL  = 3'd4
	} status_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] push_value;
		logic [QIDX_W-1:0]        queue_index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		status_t                  status;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic resp;
	} cmd_t;

endpackage

`default_nettype wire

// ----- design/stack_and_lettered_queues.sv -----
// ----------------------------------------------------------------------------
// stack_and_lettered_queues
// Value stack, hold register and lettered ring queues.
// ----------------------------------------------------------------------------
// A request (req: op, push_value, queue_index) is taken on a clock edge with
// start high and busy low. Push and pop work on the stack, pop moves the top
// into the hold register, enqueue appends the held value to the chosen queue,
// dequeue returns that queue's head.
// Each request gives one response on rsp, shown for exactly one cycle with
// done high; the receiver cannot stall and must take it then.
// The request is registered on its edge. The execute state reads or writes
// the stack or queue RAM; the respond state shows its registered read data.
// No request is taken while busy; start may be held high, and a new request
// is taken in the cycle that shows the previous response.
// Refused requests (stack empty/full, queue empty/full, unknown queue) return
// their status with read_value zero and leave all state alone.
// Reset (arst_n low) empties the stack and every queue and clears the hold
// register; no clearing pass is needed, the block is ready at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_and_lettered_queues
	import salq_pkg::*;
#(
	parameter int STACK_DEPTH = 1024,
	parameter int QUEUE_COUNT = 26,
	parameter int QUEUE_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	cmd_t cmd;

	salq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	salq_datapath #(
		.STACK_DEPTH(STACK_DEPTH),
		.QUEUE_COUNT(QUEUE_COUNT),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

// ----- design/salq_ram.sv -----
// ----------------------------------------------------------------------------
// salq_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/salq_datapath.sv -----
// ----------------------------------------------------------------------------
// salq_datapath
// Stack and queue storage, ring pointers, fill counts and hold register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salq_datapath
	import salq_pkg::*;
#(
	parameter int STACK_DEPTH = 1024,
	parameter int QUEUE_COUNT = 26,
	parameter int QUEUE_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire req_t req,
	output rsp_t      rsp
);

	localparam int SA_W = $clog2(STACK_DEPTH);
	localparam int SC_W = $clog2(STACK_DEPTH + 1);
	localparam int QP_W = $clog2(QUEUE_DEPTH);
	localparam int QF_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QS_W = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int QA_W = $clog2(QUEUE_COUNT * QUEUE_DEPTH);

	function automatic logic [QP_W-1:0] ring_next(input logic [QP_W-1:0] p);
		return (p == QP_W'(QUEUE_DEPTH - 1)) ? '0 : p + QP_W'(1);
	endfunction

	req_t              req_q;
	logic [SC_W-1:0]   stack_cnt_q;
	logic [DATA_W-1:0] held_q;
	logic [QP_W-1:0]   head_q [QUEUE_COUNT];
	logic [QP_W-1:0]   tail_q [QUEUE_COUNT];
	logic [QF_W-1:0]   fill_q [QUEUE_COUNT];
	status_t           status_q;
	logic              pop_ok_q;
	logic              deq_ok_q;

	logic              q_valid;
	logic [QS_W-1:0]   q_sel;
	logic [QP_W-1:0]   cur_head;
	logic [QP_W-1:0]   cur_tail;
	logic [QF_W-1:0]   cur_fill;
	logic [SC_W-1:0]   cnt_m1;
	status_t           st;
	logic              ok;
	logic              s_en;
	logic              s_we;
	logic [SA_W-1:0]   s_addr;
	logic [DATA_W-1:0] s_rdata;
	logic              q_en;
	logic              q_we;
	logic [QP_W-1:0]   q_ptr;
	logic [QA_W-1:0]   q_addr;
	logic [DATA_W-1:0] q_rdata;

	assign q_valid  = req_q.queue_index < QIDX_W'(QUEUE_COUNT);
	assign q_sel    = q_valid ? req_q.queue_index[QS_W-1:0] : '0;
	assign cur_head = head_q[q_sel];
	assign cur_tail = tail_q[q_sel];
	assign cur_fill = fill_q[q_sel];
	assign cnt_m1   = stack_cnt_q - SC_W'(1);

	always_comb begin
		st = ST_OK;
		case (req_q.op)
			OP_PUSH: begin
				if (stack_cnt_q == SC_W'(STACK_DEPTH)) st = ST_STACK_FULL;
			end
			OP_POP: begin
				if (stack_cnt_q == '0) st = ST_STACK_EMPTY;
			end
			OP_ENQUEUE: begin
				if (!q_valid || cur_fill == QF_W'(QUEUE_DEPTH)) st = ST_QUEUE_FULL;
			end
			OP_DEQUEUE: begin
				if (!q_valid || cur_fill == '0) st = ST_QUEUE_EMPTY;
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	assign ok     = (st == ST_OK);
	assign s_en   = cmd.exec && ok && (req_q.op == OP_PUSH || req_q.op == OP_POP);
	assign s_we   = (req_q.op == OP_PUSH);
	assign s_addr = (req_q.op == OP_PUSH) ? stack_cnt_q[SA_W-1:0] : cnt_m1[SA_W-1:0];
	assign q_en   = cmd.exec && ok && (req_q.op == OP_ENQUEUE || req_q.op == OP_DEQUEUE);
	assign q_we   = (req_q.op == OP_ENQUEUE);
	assign q_ptr  = (req_q.op == OP_ENQUEUE) ? cur_tail : cur_head;
	assign q_addr = QA_W'(q_sel) * QA_W'(QUEUE_DEPTH) + QA_W'(q_ptr);

	salq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.en   (s_en),
		.we   (s_we),
		.addr (s_addr),
		.wdata(req_q.push_value),
		.rdata(s_rdata)
	);

	salq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(QUEUE_COUNT * QUEUE_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.en   (q_en),
		.we   (q_we),
		.addr (q_addr),
		.wdata(held_q),
		.rdata(q_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= '0;
			held_q      <= '0;
			status_q    <= ST_OK;
			pop_ok_q    <= 1'b0;
			deq_ok_q    <= 1'b0;
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cmd.exec) begin
				status_q <= st;
				pop_ok_q <= ok && (req_q.op == OP_POP);
				deq_ok_q <= ok && (req_q.op == OP_DEQUEUE);
				if (ok) begin
					case (req_q.op)
						OP_PUSH: begin
							stack_cnt_q <= stack_cnt_q + SC_W'(1);
						end
						OP_POP: begin
							stack_cnt_q <= cnt_m1;
						end
						OP_ENQUEUE: begin
							tail_q[q_sel] <= ring_next(cur_tail);
							fill_q[q_sel] <= cur_fill + QF_W'(1);
						end
						OP_DEQUEUE: begin
							head_q[q_sel] <= ring_next(cur_head);
							fill_q[q_sel] <= cur_fill - QF_W'(1);
						end
						default: begin
							stack_cnt_q <= stack_cnt_q;
						end
					endcase
				end
			end
			if (cmd.resp && pop_ok_q) begin
				held_q <= s_rdata;
			end
		end
	end

	assign rsp.read_value = deq_ok_q ? q_rdata : '0;
	assign rsp.status     = status_q;

endmodule

`default_nettype wire

// ----- design/salq_ctrl.sv -----
// ----------------------------------------------------------------------------
// salq_ctrl
// Request sequencer: accept, execute, respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module salq_ctrl
	import salq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy     = (state_q == S_EXEC);
	assign done     = (state_q == S_RESP);
	assign cmd.load = start && !busy;
	assign cmd.exec = (state_q == S_EXEC);
	assign cmd.resp = (state_q == S_RESP);

	always_comb begin
		case (state_q)
			S_IDLE:  state_d = start ? S_EXEC : S_IDLE;
			S_EXEC:  state_d = S_RESP;
			S_RESP:  state_d = start ? S_EXEC : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- design/salq_checker.sv -----
// ----------------------------------------------------------------------------
// salq_checker
// Port-level checks on request/response timing and refused-response data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stack_and_lettered_queues_macros.svh"

module salq_checker
	import salq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	`SALQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not go busy")
	`SALQ_ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy not followed by a response")
	`SALQ_ASSERT_NOW(a_done_not_busy, done, !busy, "response shown while busy")
	`SALQ_ASSERT_NOW(a_refused_zero, done && rsp.status != ST_OK, rsp.read_value == '0, "refused request returned data")

endmodule

bind stack_and_lettered_queues salq_checker u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack and lettered queue block.
// ----------------------------------------------------------------------------
// Requests go in on start/busy and responses come back on done/rsp. A local
// model of the stack, the hold register and the ring queues predicts every
// response. Directed cases cover the refusals, then the stack is overfilled
// and drained, one queue is overfilled and wrapped, and a long random
// stream with random start gaps follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import salq_pkg::*;

	localparam int STACK_DEPTH  = 1024;
	localparam int QUEUE_COUNT  = 26;
	localparam int QUEUE_DEPTH  = 256;
	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 1_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	stack_and_lettered_queues #(
		.STACK_DEPTH(STACK_DEPTH),
		.QUEUE_COUNT(QUEUE_COUNT),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// model state
	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	int unsigned       stack_fill = 0;
	logic [DATA_W-1:0] held = '0;
	logic [DATA_W-1:0] ring_mem [QUEUE_COUNT][QUEUE_DEPTH];
	int unsigned       ring_head [QUEUE_COUNT];
	int unsigned       ring_tail [QUEUE_COUNT];
	int unsigned       ring_fill [QUEUE_COUNT];

	rsp_t replies_due [$];
	int   errors = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   n_refused = 0;
	int   cycle_count = 0;
	bit   gaps_on = 1'b1;
	int   hot [3];

	initial begin
		foreach (ring_head[i]) begin
			ring_head[i] = 0;
			ring_tail[i] = 0;
			ring_fill[i] = 0;
		end
	end

	function automatic rsp_t step_stack_queues(req_t r);
		rsp_t        o;
		int unsigned q;
		o.read_value = '0;
		o.status     = ST_OK;
		q = r.queue_index;
		case (r.op)
			OP_PUSH: begin
				if (stack_fill >= STACK_DEPTH) begin
					o.status = ST_STACK_FULL;
				end else begin
					stack_mem[stack_fill] = r.push_value;
					stack_fill++;
				end
			end
			OP_POP: begin
				if (stack_fill == 0) begin
					o.status = ST_STACK_EMPTY;
				end else begin
					stack_fill--;
					held = stack_mem[stack_fill];
				end
			end
			OP_ENQUEUE: begin
				if (q >= QUEUE_COUNT || ring_fill[q] >= QUEUE_DEPTH) begin
					o.status = ST_QUEUE_FULL;
				end else begin
					ring_mem[q][ring_tail[q]] = held;
					ring_tail[q] = (ring_tail[q] + 1 >= QUEUE_DEPTH) ? 0 : ring_tail[q] + 1;
					ring_fill[q]++;
				end
			end
			default: begin
				if (q >= QUEUE_COUNT || ring_fill[q] == 0) begin
					o.status = ST_QUEUE_EMPTY;
				end else begin
					o.read_value = ring_mem[q][ring_head[q]];
					ring_head[q] = (ring_head[q] + 1 >= QUEUE_DEPTH) ? 0 : ring_head[q] + 1;
					ring_fill[q]--;
				end
			end
		endcase
		return o;
	endfunction

	function automatic req_t make_req(op_t code, logic [DATA_W-1:0] value, int qi);
		req_t r;
		r.op          = code;
		r.push_value  = value;
		r.queue_index = qi[QIDX_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		case (r % 4)
			0: return (r < 10) ? 32'h7fff_ffff : $urandom;
			1: return (r < 10) ? 32'h8000_0000 : $urandom;
			2: return (r < 10) ? 32'hffff_ffff : $urandom;
			default: return (r < 10) ? 32'h0000_0000 : $urandom;
		endcase
	endfunction

	task automatic send_request(req_t r);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		replies_due.push_back(step_stack_queues(r));
		n_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic report_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		errors++;
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (replies_due.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = replies_due.pop_front();
					n_checked++;
					if (want.status != ST_OK)
						n_refused++;
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want.status));
					if (rsp.read_value !== want.read_value)
						report_mismatch($sformatf("read_value %h, want %h",
							rsp.read_value, want.read_value));
				end
			end else if (done !== 1'b0) begin
				report_mismatch("done unknown");
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, replies_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
		send_request(make_req(OP_DEQUEUE, $urandom, 0));
		send_request(make_req(OP_DEQUEUE, $urandom, 31));
		send_request(make_req(OP_ENQUEUE, $urandom, 26));
		send_request(make_req(OP_ENQUEUE, $urandom, 0));
		send_request(make_req(OP_DEQUEUE, $urandom, 0));
		send_request(make_req(OP_PUSH, 32'h7fff_ffff, $urandom_range(0, 31)));
		send_request(make_req(OP_PUSH, 32'h8000_0000, $urandom_range(0, 31)));
		send_request(make_req(OP_PUSH, 32'hffff_ffff, $urandom_range(0, 31)));
		send_request(make_req(OP_PUSH, 32'h0000_0000, $urandom_range(0, 31)));
		send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
		send_request(make_req(OP_ENQUEUE, $urandom, 25));
		send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
		send_request(make_req(OP_ENQUEUE, $urandom, 25));
		send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
		send_request(make_req(OP_ENQUEUE, $urandom, 0));
		send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
		// refused pop keeps the held value
		send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
		send_request(make_req(OP_ENQUEUE, $urandom, 25));
		send_request(make_req(OP_ENQUEUE, $urandom, 31));
		send_request(make_req(OP_DEQUEUE, $urandom, 25));
		send_request(make_req(OP_DEQUEUE, $urandom, 25));
		send_request(make_req(OP_DEQUEUE, $urandom, 25));
		send_request(make_req(OP_DEQUEUE, $urandom, 0));
		send_request(make_req(OP_DEQUEUE, $urandom, 26));
	endtask

	task automatic test_stack_overflow();
		repeat (STACK_DEPTH + 2)
			send_request(make_req(OP_PUSH, pick_value(), $urandom_range(0, 31)));
		repeat (STACK_DEPTH + 2)
			send_request(make_req(OP_POP, $urandom, $urandom_range(0, 31)));
	endtask

	task automatic test_queue_ring();
		int letter;
		letter = $urandom_range(0, QUEUE_COUNT - 1);
		// fill past full, drain half, refill to wrap the ring, then drain past empty
		repeat (QUEUE_DEPTH + 1) begin
			send_request(make_req(OP_PUSH, pick_value(), letter));
			send_request(make_req(OP_POP, $urandom, letter));
			send_request(make_req(OP_ENQUEUE, $urandom, letter));
		end
		repeat (QUEUE_DEPTH / 2)
			send_request(make_req(OP_DEQUEUE, $urandom, letter));
		repeat (QUEUE_DEPTH / 2 + 1) begin
			send_request(make_req(OP_PUSH, pick_value(), letter));
			send_request(make_req(OP_POP, $urandom, letter));
			send_request(make_req(OP_ENQUEUE, $urandom, letter));
		end
		repeat (QUEUE_DEPTH + 1)
			send_request(make_req(OP_DEQUEUE, $urandom, letter));
	endtask

	task automatic test_random();
		int   r;
		int   qi;
		op_t  code;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0) begin
				foreach (hot[k])
					hot[k] = $urandom_range(0, QUEUE_COUNT - 1);
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			r = $urandom_range(0, 99);
			if (r < 28)
				code = OP_PUSH;
			else if (r < 52)
				code = OP_POP;
			else if (r < 78)
				code = OP_ENQUEUE;
			else
				code = OP_DEQUEUE;
			r = $urandom_range(0, 99);
			if (r < 45)
				qi = hot[$urandom_range(0, 2)];
			else if (r < 92)
				qi = $urandom_range(0, QUEUE_COUNT - 1);
			else
				qi = $urandom_range(QUEUE_COUNT, 31);
			send_request(make_req(code, pick_value(), qi));
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_stack_overflow();
		test_queue_ring();
		test_random();

		@(negedge clk);
		start <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("%0d requests sent, %0d responses checked, %0d of them refusals",
			n_sent, n_checked, n_refused);
		$display("covered: stack overflow and underflow, queue ring wrap, bad letters");
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
